// ===== hdl/alos_pkg.sv =====
// Shared types, operand codes and gain tables for the attitude LQR observer step unit.
package alos_pkg;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_RDA, ST_RDB, ST_LDB, ST_MUL, ST_RND, ST_ACC,
      ST_SQI, ST_SQS, ST_SQD, ST_FIN
   } state_type;

   typedef enum logic [1:0] {PH_SQ, PH_ERR, PH_GAIN, PH_OBS} phase_type;

   typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} acc_mode_type;

   // Bits of the multiplier operand consumed per cycle.
   localparam int DIGIT_BITS = 8;

   // Input words carried in tdata, output words in rsp tdata.
   localparam int N_IN_WORDS  = 10;
   localparam int N_OUT_WORDS = 3;

   // Logical operand codes of the scratch memory.
   localparam logic [5:0] OPC_EST0 = 6'd0;
   localparam logic [5:0] OPC_NX0  = 6'd9;
   localparam logic [5:0] OPC_Y0   = 6'd18;
   localparam logic [5:0] OPC_RQ0  = 6'd24;
   localparam logic [5:0] OPC_Q0   = 6'd28;
   localparam logic [5:0] OPC_E0   = 6'd29;
   localparam logic [5:0] OPC_U0   = 6'd32;
   localparam int MEM_DEPTH = 35;

   // Feedback gains, mantissa times ten to the minus exponent, row by axis.
   localparam int K_MANT [9] = '{
      -6056396, -5003111, -7059808,
      -6067506, -5092506, -7046706,
      -6636501, -8445669, -5312532 };
   localparam int K_EXP [9] = '{6, 7, 8, 6, 7, 8, 6, 7, 9};

   // Observer gains: per row three state terms, two measurement terms, one action term.
   localparam int O_MANT [54] = '{
      9989497, -2798788, 1397984, -1050342, -2380719, 6584711,
      9989497, -2695783, 1319862, -1050345, -2370419, 6216742,
      9983210, -1674405, -8212841, -1678986, -2268281, 1053391,
      -4500051, 7245060, 1304781, -4500051, -2754940, 9310577,
      -4527181, 7344537, 1231867, -4527181, -2655463, 8790280,
      -1127559, 7698489, -7665294, -1127559, -2301511, 9849575,
      5925511, -2175075, 8868778, 5925511, -2175075, 1318439,
      5830821, -2148486, 8868778, 5830821, -2148486, 1318439,
      2498255, -2959738, 8868778, 2498255, -2959738, 1318439 };
   localparam int O_EXP [54] = '{
      7, 10, 11, 9, 9, 11,
      7, 10, 11, 9, 9, 11,
      7, 10, 12, 9, 9, 9,
      10, 7, 8, 10, 7, 8,
      10, 7, 8, 10, 7, 8,
      9, 7, 9, 9, 7, 7,
      10, 6, 7, 10, 6, 5,
      10, 6, 7, 10, 6, 5,
      10, 6, 7, 10, 6, 5 };

   // Magnitude of a decimal gain in fixed point, rounded half up.
   // Only ever evaluated on constants at elaboration.
   function automatic logic [63:0] coef_mag(input int mant, input int expo, input int frac);
      logic [63:0] d;
      logic [63:0] a;
      logic [63:0] v;
      logic [63:0] r;
      d = 64'd1;
      for (int i = 0; i < expo; i++) begin
         d = d * 64'd10;
      end
      a = (mant < 0) ? 64'(-mant) : 64'(mant);
      v = '0;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         v = {v[62:0], 1'b0};
         if (r >= d) begin
            r = r - d;
            v[0] = 1'b1;
         end
      end
      for (int i = 0; i <= frac; i++) begin
         r = {r[62:0], 1'b0};
         v = {v[62:0], 1'b0};
         if (r >= d) begin
            r = r - d;
            v[0] = 1'b1;
         end
      end
      return (v + 64'd1) >> 1;
   endfunction

endpackage

// ===== hdl/attitude_lqr_observer_step_unit.sv =====
// Attitude LQR state feedback with observer update, one control tick per input beat.
// A new beat is accepted only while idle, after the result of the last tick has been
// registered. All 78 products go through one digit-serial multiplier of NDIG digits
// (6), 8 bits per cycle, and the square root of RB = (WORD_BITS+FRAC_BITS)/2 bits
// takes one result bit per cycle.
// Reset (synchronous, active high) clears the control state and marks the estimate as zero.
module attitude_lqr_observer_step_unit #(
   parameter int WORD_BITS = 48,
   parameter int FRAC_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // meas_q1, meas_q2, meas_q3, rate_x, rate_y, rate_z, ref_w, ref_x, ref_y, ref_z
   input  logic [((alos_pkg::N_IN_WORDS*WORD_BITS+7)/8)*8-1:0] req_tdata,
   // meas_q0_negative
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // action_x, action_y, action_z
   output logic [((alos_pkg::N_OUT_WORDS*WORD_BITS+7)/8)*8-1:0] rsp_tdata
);

   localparam int W     = WORD_BITS;
   localparam int MW    = (WORD_BITS > FRAC_BITS + 5) ? WORD_BITS : FRAC_BITS + 5;
   localparam int D     = alos_pkg::DIGIT_BITS;
   localparam int NDIG  = (MW + D - 1) / D;
   localparam int BW    = NDIG * D;
   localparam int PW    = MW + BW + 2;
   localparam int RB    = (WORD_BITS + FRAC_BITS) / 2;
   localparam int SQW   = RB + WORD_BITS;
   localparam int CNTW  = $clog2(((RB > NDIG) ? RB : NDIG) + 1);
   localparam int INW   = alos_pkg::N_IN_WORDS * WORD_BITS;
   localparam int OUTW  = alos_pkg::N_OUT_WORDS * WORD_BITS;
   localparam int OUTB  = ((alos_pkg::N_OUT_WORDS * WORD_BITS + 7) / 8) * 8;

   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ONE_W =
      (FRAC_BITS >= WORD_BITS - 1) ? WMAX : (WORD_BITS'(1) << FRAC_BITS);
   localparam logic signed [PW-1:0] PMAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [PW-1:0] PMIN = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};
   localparam logic signed [PW-1:0] PHALF = PW'(1) <<< (FRAC_BITS - 1);

   // Sequencer and step counters.
   alos_pkg::state_type state_ff, state_in;
   alos_pkg::phase_type phase_ff;
   logic [3:0] row_ff;
   logic [2:0] term_ff;
   logic [1:0] ax_ff;
   logic [3:0] ld_cnt_ff;
   logic [CNTW-1:0] cnt_ff;

   // Input capture, shifted out one word per cycle into the scratch memory.
   logic [INW-1:0] in_ff;
   logic qneg_ff;

   // The estimate lives in two banks; the live bank is read, the other receives the update.
   logic bank_ff;
   logic est_zero_ff;

   // Scratch memory with one write and one registered read port.
   logic signed [W-1:0] mem [alos_pkg::MEM_DEPTH];
   logic signed [W-1:0] rd_ff;
   logic rd_zero_ff;
   logic [5:0] rd_code;
   logic [5:0] rd_addr;
   logic wr_en;
   logic [5:0] wr_addr;
   logic signed [W-1:0] wr_data;
   logic signed [W-1:0] rdval;

   // Digit-serial multiplier and accumulator.
   logic signed [W-1:0] a_ff;
   logic [MW-1:0] amag_ff;
   logic [BW-1:0] bsh_ff;
   logic neg_ff;
   logic [MW+BW-1:0] pacc_ff;
   logic [MW+D-1:0] ptop;
   logic signed [W-1:0] prod_ff;
   logic signed [W-1:0] prod_rnd;
   logic signed [PW-1:0] sp;
   logic signed [PW-1:0] rs;
   logic signed [W-1:0] acc_ff;
   logic signed [W-1:0] acc_res;

   // Bit-serial square root.
   logic [2*RB-1:0] rad_ff;
   logic [RB:0] rem_ff;
   logic [RB-1:0] root_ff;
   logic [RB+2:0] rem2;
   logic [RB+2:0] trial;
   logic signed [W-1:0] arg_sat;
   logic signed [W-1:0] q0v;
   logic [SQW-1:0] root_ext;

   // Actions of this tick and the result register.
   logic signed [W-1:0] act_ff [alos_pkg::N_OUT_WORDS];
   logic rsp_valid_ff;
   logic [OUTW-1:0] rsp_data_ff;

   // Decoded micro-operation.
   logic [5:0] a_code;
   logic [5:0] b_code;
   logic b_coef;
   logic [MW-1:0] c_mag;
   logic c_neg;
   alos_pkg::acc_mode_type mode;
   logic last_term;
   logic [5:0] dest_code;
   logic phase_end;
   logic [3:0] kidx;
   logic [5:0] oidx;

   // Gain constants, fixed at elaboration for the chosen fraction width.
   logic [MW-1:0] kmag [9];
   logic kneg [9];
   logic [MW-1:0] omag [54];
   logic oneg [54];

   genvar g;
   for (g = 0; g < 9; g++) begin : g_kgain
      assign kmag[g] = MW'(alos_pkg::coef_mag(alos_pkg::K_MANT[g], alos_pkg::K_EXP[g],
                                              FRAC_BITS));
      assign kneg[g] = (alos_pkg::K_MANT[g] < 0);
   end
   for (g = 0; g < 54; g++) begin : g_ogain
      assign omag[g] = MW'(alos_pkg::coef_mag(alos_pkg::O_MANT[g], alos_pkg::O_EXP[g],
                                              FRAC_BITS));
      assign oneg[g] = (alos_pkg::O_MANT[g] < 0);
   end

   // Saturate a sum two bits wider than the word.
   function automatic logic signed [W-1:0] sat_word(input logic signed [W+1:0] s);
      logic signed [W+1:0] smax;
      logic signed [W+1:0] smin;
      smax = {3'b000, {(W-1){1'b1}}};
      smin = {3'b111, {(W-1){1'b0}}};
      if (s > smax) begin
         return WMAX;
      end else if (s < smin) begin
         return WMIN;
      end
      return s[W-1:0];
   endfunction

   // Magnitude of a word; the most negative word fits as an unsigned value.
   function automatic logic [MW-1:0] mag_of(input logic signed [W-1:0] v);
      logic signed [W:0] x;
      x = {v[W-1], v};
      if (x < 0) begin
         x = -x;
      end
      return MW'(x[W-1:0]);
   endfunction

   // Estimate codes map onto the live bank, update codes onto the other one.
   function automatic logic [5:0] phys(input logic [5:0] code, input logic bank);
      if (code < alos_pkg::OPC_NX0) begin
         return bank ? code + alos_pkg::OPC_NX0 : code;
      end else if (code < alos_pkg::OPC_Y0) begin
         return bank ? code - alos_pkg::OPC_NX0 : code;
      end
      return code;
   endfunction

   assign kidx = 4'(row_ff * 4'd3) + 4'(term_ff);
   assign oidx = 6'({2'b00, row_ff} * 6'd6) + 6'(term_ff);

   // Micro-operation decode from phase, row and term.
   always_comb begin
      a_code    = alos_pkg::OPC_EST0;
      b_code    = alos_pkg::OPC_EST0;
      b_coef    = 1'b0;
      c_mag     = '0;
      c_neg     = 1'b0;
      mode      = alos_pkg::ACC_LOAD;
      last_term = 1'b0;
      dest_code = alos_pkg::OPC_Q0;
      phase_end = 1'b0;
      case (phase_ff)
         alos_pkg::PH_SQ: begin
            // Squared norm of the estimated vector part.
            a_code    = alos_pkg::OPC_EST0 + 6'(term_ff);
            b_code    = alos_pkg::OPC_EST0 + 6'(term_ff);
            mode      = (term_ff == 3'd0) ? alos_pkg::ACC_LOAD : alos_pkg::ACC_ADD;
            last_term = (term_ff == 3'd2);
            phase_end = 1'b1;
         end
         alos_pkg::PH_ERR: begin
            // Quaternion error, one axis per row, four products each.
            last_term = (term_ff == 3'd3);
            dest_code = alos_pkg::OPC_E0 + 6'(row_ff);
            phase_end = (row_ff == 4'd2);
            case ({row_ff[1:0], term_ff[1:0]})
               4'b00_00: begin
                  a_code = alos_pkg::OPC_EST0;     b_code = alos_pkg::OPC_RQ0;
                  mode = alos_pkg::ACC_LOAD;
               end
               4'b00_01: begin
                  a_code = alos_pkg::OPC_RQ0 + 6'd1; b_code = alos_pkg::OPC_Q0;
                  mode = alos_pkg::ACC_SUB;
               end
               4'b00_10: begin
                  a_code = alos_pkg::OPC_EST0 + 6'd2; b_code = alos_pkg::OPC_RQ0 + 6'd2;
                  mode = alos_pkg::ACC_ADD;
               end
               4'b00_11: begin
                  a_code = alos_pkg::OPC_RQ0 + 6'd3; b_code = alos_pkg::OPC_EST0 + 6'd1;
                  mode = alos_pkg::ACC_SUB;
               end
               4'b01_00: begin
                  a_code = alos_pkg::OPC_EST0 + 6'd1; b_code = alos_pkg::OPC_RQ0;
                  mode = alos_pkg::ACC_LOAD;
               end
               4'b01_01: begin
                  a_code = alos_pkg::OPC_RQ0 + 6'd1; b_code = alos_pkg::OPC_EST0 + 6'd2;
                  mode = alos_pkg::ACC_SUB;
               end
               4'b01_10: begin
                  a_code = alos_pkg::OPC_Q0;       b_code = alos_pkg::OPC_RQ0 + 6'd2;
                  mode = alos_pkg::ACC_SUB;
               end
               4'b01_11: begin
                  a_code = alos_pkg::OPC_RQ0 + 6'd3; b_code = alos_pkg::OPC_EST0;
                  mode = alos_pkg::ACC_ADD;
               end
               4'b10_00: begin
                  a_code = alos_pkg::OPC_EST0 + 6'd2; b_code = alos_pkg::OPC_RQ0;
                  mode = alos_pkg::ACC_LOAD;
               end
               4'b10_01: begin
                  a_code = alos_pkg::OPC_RQ0 + 6'd1; b_code = alos_pkg::OPC_EST0 + 6'd1;
                  mode = alos_pkg::ACC_ADD;
               end
               4'b10_10: begin
                  a_code = alos_pkg::OPC_EST0;     b_code = alos_pkg::OPC_RQ0 + 6'd2;
                  mode = alos_pkg::ACC_SUB;
               end
               4'b10_11: begin
                  a_code = alos_pkg::OPC_RQ0 + 6'd3; b_code = alos_pkg::OPC_Q0;
                  mode = alos_pkg::ACC_SUB;
               end
               default: begin
                  a_code = alos_pkg::OPC_EST0;     b_code = alos_pkg::OPC_EST0;
                  mode = alos_pkg::ACC_LOAD;
               end
            endcase
         end
         alos_pkg::PH_GAIN: begin
            // Diagonal feedback: error, rate and extra state of one axis.
            a_code    = (term_ff == 3'd0) ? alos_pkg::OPC_E0 + 6'(row_ff)
                      : alos_pkg::OPC_EST0 + 6'(term_ff * 3'd3) + 6'(row_ff);
            b_coef    = 1'b1;
            c_mag     = kmag[kidx];
            c_neg     = kneg[kidx];
            mode      = (term_ff == 3'd0) ? alos_pkg::ACC_LOAD : alos_pkg::ACC_ADD;
            last_term = (term_ff == 3'd2);
            dest_code = alos_pkg::OPC_U0 + 6'(row_ff);
            phase_end = (row_ff == 4'd2);
         end
         alos_pkg::PH_OBS: begin
            // Observer row: three state terms, two measurements subtracted, one action.
            b_coef    = 1'b1;
            c_mag     = omag[oidx];
            c_neg     = oneg[oidx];
            last_term = (term_ff == 3'd5);
            dest_code = alos_pkg::OPC_NX0 + 6'(row_ff);
            phase_end = (row_ff == 4'd8);
            case (term_ff)
               3'd0: begin
                  a_code = alos_pkg::OPC_EST0 + 6'(ax_ff); mode = alos_pkg::ACC_LOAD;
               end
               3'd1: begin
                  a_code = alos_pkg::OPC_EST0 + 6'd3 + 6'(ax_ff); mode = alos_pkg::ACC_ADD;
               end
               3'd2: begin
                  a_code = alos_pkg::OPC_EST0 + 6'd6 + 6'(ax_ff); mode = alos_pkg::ACC_ADD;
               end
               3'd3: begin
                  a_code = alos_pkg::OPC_Y0 + 6'(ax_ff); mode = alos_pkg::ACC_SUB;
               end
               3'd4: begin
                  a_code = alos_pkg::OPC_Y0 + 6'd3 + 6'(ax_ff); mode = alos_pkg::ACC_SUB;
               end
               3'd5: begin
                  a_code = alos_pkg::OPC_U0 + 6'(ax_ff); mode = alos_pkg::ACC_ADD;
               end
               default: begin
                  a_code = alos_pkg::OPC_EST0; mode = alos_pkg::ACC_LOAD;
               end
            endcase
         end
         default: begin
            a_code = alos_pkg::OPC_EST0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         alos_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = alos_pkg::ST_LOAD;
         end
         alos_pkg::ST_LOAD: begin
            if (ld_cnt_ff == 4'(alos_pkg::N_IN_WORDS - 1)) state_in = alos_pkg::ST_RDA;
         end
         alos_pkg::ST_RDA: state_in = alos_pkg::ST_RDB;
         alos_pkg::ST_RDB: state_in = alos_pkg::ST_LDB;
         alos_pkg::ST_LDB: state_in = alos_pkg::ST_MUL;
         alos_pkg::ST_MUL: begin
            if (cnt_ff == CNTW'(NDIG - 1)) state_in = alos_pkg::ST_RND;
         end
         alos_pkg::ST_RND: state_in = alos_pkg::ST_ACC;
         alos_pkg::ST_ACC: begin
            if (last_term && phase_end) begin
               case (phase_ff)
                  alos_pkg::PH_SQ:  state_in = alos_pkg::ST_SQI;
                  alos_pkg::PH_OBS: state_in = alos_pkg::ST_FIN;
                  default:          state_in = alos_pkg::ST_RDA;
               endcase
            end else begin
               state_in = alos_pkg::ST_RDA;
            end
         end
         alos_pkg::ST_SQI: state_in = alos_pkg::ST_SQS;
         alos_pkg::ST_SQS: begin
            if (cnt_ff == CNTW'(RB - 1)) state_in = alos_pkg::ST_SQD;
         end
         alos_pkg::ST_SQD: state_in = alos_pkg::ST_RDA;
         alos_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) state_in = alos_pkg::ST_IDLE;
         end
         default: state_in = alos_pkg::ST_IDLE;
      endcase
   end

   // Handshake, memory port control.
   always_comb begin
      req_tready = 1'b0;
      rd_code    = alos_pkg::OPC_Y0;
      wr_en      = 1'b0;
      wr_addr    = alos_pkg::OPC_Y0 + 6'(ld_cnt_ff);
      wr_data    = in_ff[W-1:0];
      case (state_ff)
         alos_pkg::ST_IDLE: req_tready = 1'b1;
         alos_pkg::ST_LOAD: wr_en = 1'b1;
         alos_pkg::ST_RDA:  rd_code = a_code;
         alos_pkg::ST_RDB:  rd_code = b_code;
         alos_pkg::ST_ACC: begin
            wr_en   = last_term && (phase_ff != alos_pkg::PH_SQ);
            wr_addr = phys(dest_code, bank_ff);
            wr_data = acc_res;
         end
         alos_pkg::ST_SQD: begin
            wr_en   = 1'b1;
            wr_addr = alos_pkg::OPC_Q0;
            wr_data = q0v;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign rd_addr = phys(rd_code, bank_ff);
   assign rdval   = rd_zero_ff ? '0 : rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // One multiplier digit: add amag times the low digit, then shift right.
   assign ptop = {{D{1'b0}}, pacc_ff[MW+BW-1:BW]} + (amag_ff * bsh_ff[D-1:0]);

   // Round half up at the binary point, then saturate to the word.
   always_comb begin
      sp = $signed({2'b00, pacc_ff});
      if (neg_ff) begin
         sp = -sp;
      end
      rs = (sp + PHALF) >>> FRAC_BITS;
      if (rs > PMAX) begin
         prod_rnd = WMAX;
      end else if (rs < PMIN) begin
         prod_rnd = WMIN;
      end else begin
         prod_rnd = rs[W-1:0];
      end
   end

   always_comb begin
      case (mode)
         alos_pkg::ACC_ADD: acc_res = sat_word({{2{acc_ff[W-1]}}, acc_ff}
                                               + {{2{prod_ff[W-1]}}, prod_ff});
         alos_pkg::ACC_SUB: acc_res = sat_word({{2{acc_ff[W-1]}}, acc_ff}
                                               - {{2{prod_ff[W-1]}}, prod_ff});
         default:           acc_res = prod_ff;
      endcase
   end

   // Square root argument: one minus the squared norm, clamped at zero.
   assign arg_sat = sat_word({{2{ONE_W[W-1]}}, ONE_W} - {{2{acc_ff[W-1]}}, acc_ff});
   assign rem2    = {rem_ff, rad_ff[2*RB-1:2*RB-2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign root_ext = SQW'(root_ff);

   always_comb begin
      if (root_ext > SQW'(WMAX)) begin
         q0v = WMAX;
      end else begin
         q0v = root_ext[W-1:0];
      end
      if (qneg_ff) begin
         q0v = -q0v;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alos_pkg::ST_IDLE;
         phase_ff     <= alos_pkg::PH_SQ;
         row_ff       <= '0;
         term_ff      <= '0;
         ax_ff        <= '0;
         ld_cnt_ff    <= '0;
         cnt_ff       <= '0;
         bank_ff      <= 1'b0;
         est_zero_ff  <= 1'b1;
         rd_zero_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_zero_ff <= est_zero_ff && (rd_code < alos_pkg::OPC_NX0);
         // A new result may load in the same cycle as the old one leaves.
         if (state_ff == alos_pkg::ST_FIN && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            alos_pkg::ST_IDLE: begin
               ld_cnt_ff <= '0;
               phase_ff  <= alos_pkg::PH_SQ;
               row_ff    <= '0;
               term_ff   <= '0;
               ax_ff     <= '0;
            end
            alos_pkg::ST_LOAD: ld_cnt_ff <= ld_cnt_ff + 4'd1;
            alos_pkg::ST_LDB:  cnt_ff <= '0;
            alos_pkg::ST_MUL:  cnt_ff <= cnt_ff + CNTW'(1);
            alos_pkg::ST_ACC: begin
               if (last_term) begin
                  term_ff <= '0;
                  if (phase_end) begin
                     row_ff <= '0;
                     ax_ff  <= '0;
                     case (phase_ff)
                        alos_pkg::PH_SQ:   phase_ff <= alos_pkg::PH_ERR;
                        alos_pkg::PH_ERR:  phase_ff <= alos_pkg::PH_GAIN;
                        alos_pkg::PH_GAIN: phase_ff <= alos_pkg::PH_OBS;
                        default:           phase_ff <= alos_pkg::PH_OBS;
                     endcase
                  end else begin
                     row_ff <= row_ff + 4'd1;
                     ax_ff  <= (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
                  end
               end else begin
                  term_ff <= term_ff + 3'd1;
               end
            end
            alos_pkg::ST_SQI: cnt_ff <= '0;
            alos_pkg::ST_SQS: cnt_ff <= cnt_ff + CNTW'(1);
            alos_pkg::ST_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  bank_ff      <= ~bank_ff;
                  est_zero_ff  <= 1'b0;
               end
            end
            default: begin
               cnt_ff <= cnt_ff;
            end
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         alos_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               in_ff   <= req_tdata[INW-1:0];
               qneg_ff <= req_tuser[0];
            end
         end
         alos_pkg::ST_LOAD: in_ff <= in_ff >> W;
         alos_pkg::ST_RDB:  a_ff <= rdval;
         alos_pkg::ST_LDB: begin
            amag_ff <= mag_of(a_ff);
            bsh_ff  <= b_coef ? BW'(c_mag) : BW'(mag_of(rdval));
            neg_ff  <= a_ff[W-1] ^ (b_coef ? c_neg : rdval[W-1]);
            pacc_ff <= '0;
         end
         alos_pkg::ST_MUL: begin
            pacc_ff <= {ptop, pacc_ff[BW-1:D]};
            bsh_ff  <= bsh_ff >> D;
         end
         alos_pkg::ST_RND: prod_ff <= prod_rnd;
         alos_pkg::ST_ACC: begin
            acc_ff <= acc_res;
            if (last_term && (phase_ff == alos_pkg::PH_GAIN)) begin
               act_ff[row_ff[1:0]] <= acc_res;
            end
         end
         alos_pkg::ST_SQI: begin
            rad_ff  <= (2*RB)'(arg_sat[W-1] ? '0 : arg_sat[W-2:0]) << FRAC_BITS;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         alos_pkg::ST_SQS: begin
            rad_ff <= rad_ff << 2;
            if (rem2 >= trial) begin
               rem_ff  <= (RB+1)'(rem2 - trial);
               root_ff <= {root_ff[RB-2:0], 1'b1};
            end else begin
               rem_ff  <= rem2[RB:0];
               root_ff <= {root_ff[RB-2:0], 1'b0};
            end
         end
         alos_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_ff <= {act_ff[2], act_ff[1], act_ff[0]};
            end
         end
         default: begin
            prod_ff <= prod_ff;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUTB'(rsp_data_ff);

   // A finished tick always leaves the estimate live.
   a_est_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == alos_pkg::ST_FIN && (!rsp_valid_ff || rsp_tready)) |=> !est_zero_ff)
      else $error("estimate still marked zero after a tick");

   // The rebuilt scalar part never exceeds one.
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == alos_pkg::ST_SQD) |-> (root_ext <= (SQW'(1) << FRAC_BITS)))
      else $error("square root above one");

   // An accepted beat goes straight into the load sweep.
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == alos_pkg::ST_LOAD && ld_cnt_ff == 4'd0))
      else $error("accepted beat not loaded");

   // The multiplier never runs past its digit count.
   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == alos_pkg::ST_MUL) |-> (cnt_ff < CNTW'(NDIG)))
      else $error("multiplier digit count overrun");

endmodule
